### rtl/fve_pkg.sv
// ----------------------------------------------------------------------------
// fve_pkg: shared types and helpers of the form value percent encoder
// Command format between front and back, back phase codes, character
// constants and the character class and hex digit functions.
// ----------------------------------------------------------------------------
package fve_pkg;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_EQ    = 8'h3d;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;
   localparam logic [7:0] CHAR_BSL   = 8'h5c;
   localparam logic [7:0] CHAR_DASH  = 8'h2d;
   localparam logic [7:0] CHAR_UNDER = 8'h5f;
   localparam logic [7:0] CHAR_COLON = 8'h3a;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_PLAIN,
      MODE_ESCAPE
   } mode_type;

   typedef enum logic [1:0] {
      PH_SEP,
      PH_MAIN,
      PH_HEX_HI,
      PH_HEX_LO
   } phase_type;

   typedef struct packed {
      logic       sep;
      mode_type   mode;
      logic [7:0] data;
      logic       last;
   } cmd_type;

   function automatic logic passes_plain(input logic [7:0] c);
      logic ok;
      ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a) ||
           c == CHAR_AT || c == CHAR_DOT || c == CHAR_SLASH || c == CHAR_BSL ||
           c == CHAR_DASH || c == CHAR_UNDER || c == CHAR_COLON;
      return ok;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] d;
      if (v < 4'd10) begin
         d = 8'h30 + {4'h0, v};
      end else begin
         d = 8'h57 + {4'h0, v};
      end
      return d;
   endfunction

endpackage

### rtl/fve_front.sv
// ----------------------------------------------------------------------------
// fve_front: field tracking and classification
// Accepts input bytes, tracks field and value state, and turns each byte
// into a command for the back end (separator flag, plain or escape, end).
// ----------------------------------------------------------------------------
module fve_front
   import fve_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       cmd_push,
   output cmd_type    cmd,
   input  logic       q_full
);

   logic in_value_part_ff, in_value_part_in;
   logic in_field_ff, in_field_in;
   logic any_sent_ff, any_sent_in;
   logic sep_pending_ff, sep_pending_in;
   logic accept, is_amp;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign is_amp   = (req_in_byte == CHAR_AMP);

   always_comb begin
      cmd.sep  = !is_amp && !in_field_ff && sep_pending_ff && any_sent_ff;
      cmd.data = req_in_byte;
      cmd.last = req_in_last;
      if (is_amp) begin
         cmd.mode = MODE_NONE;
      end else if (!in_value_part_ff || passes_plain(req_in_byte)) begin
         cmd.mode = MODE_PLAIN;
      end else begin
         cmd.mode = MODE_ESCAPE;
      end
   end

   // drop ampersands that end no message
   assign cmd_push = accept && (!is_amp || req_in_last);

   always_comb begin
      in_value_part_in = in_value_part_ff;
      in_field_in      = in_field_ff;
      any_sent_in      = any_sent_ff;
      sep_pending_in   = sep_pending_ff;
      if (accept) begin
         priority if (req_in_last) begin
            in_value_part_in = 1'b0;
            in_field_in      = 1'b0;
            any_sent_in      = 1'b0;
            sep_pending_in   = 1'b0;
         end else if (is_amp) begin
            sep_pending_in   = sep_pending_ff || in_field_ff;
            in_field_in      = 1'b0;
            in_value_part_in = 1'b0;
         end else begin
            if (!in_field_ff) begin
               sep_pending_in = 1'b0;
               in_field_in    = 1'b1;
               any_sent_in    = 1'b1;
            end
            if (!in_value_part_ff && req_in_byte == CHAR_EQ) begin
               in_value_part_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_value_part_ff <= 1'b0;
         in_field_ff      <= 1'b0;
         any_sent_ff      <= 1'b0;
         sep_pending_ff   <= 1'b0;
      end else begin
         in_value_part_ff <= in_value_part_in;
         in_field_ff      <= in_field_in;
         any_sent_ff      <= any_sent_in;
         sep_pending_ff   <= sep_pending_in;
      end
   end

endmodule

### rtl/fve_queue.sv
// ----------------------------------------------------------------------------
// fve_queue: command queue between front and back
// Small circular buffer of commands with occupancy count.
// ----------------------------------------------------------------------------
module fve_queue
   import fve_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   cmd_type            mem_ff [QDEPTH];
   logic [QAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]     count_ff, count_in;
   logic               push_ok, pop_ok;

   assign full    = (count_ff == QCW'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCW'(push_ok) - QCW'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCW'(QDEPTH))
      else $error("queue count exceeds depth");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QCW'(QDEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push_ok && !pop_ok |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance on push");

endmodule

### rtl/fve_back.sv
// ----------------------------------------------------------------------------
// fve_back: command expansion and result register
// Expands each command into an optional separator and one plain byte, a
// three-character escape or bare end marker, one char a cycle unless stalled.
// ----------------------------------------------------------------------------
module fve_back
   import fve_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_out_last
);

   phase_type  phase_ff, phase_in;
   phase_type  cur_phase;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, piece_byte;
   logic       has_byte_ff, piece_has;
   logic       last_ff, piece_last;
   logic       piece_final;
   logic       advance;

   assign cur_phase = (phase_ff == PH_SEP && !head.sep) ? PH_MAIN : phase_ff;
   assign advance   = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop     = advance && piece_final;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         if (piece_final) begin
            phase_in = PH_SEP;
         end else begin
            unique case (cur_phase)
               PH_SEP:    phase_in = PH_MAIN;
               PH_MAIN:   phase_in = PH_HEX_HI;
               PH_HEX_HI: phase_in = PH_HEX_LO;
               PH_HEX_LO: phase_in = PH_SEP;
               default:   phase_in = PH_SEP;
            endcase
         end
      end
   end

   // piece outputs
   always_comb begin
      piece_byte  = 8'h00;
      piece_has   = 1'b1;
      piece_final = 1'b0;
      unique case (cur_phase)
         PH_SEP: begin
            piece_byte = CHAR_AMP;
         end
         PH_MAIN: begin
            unique case (head.mode)
               MODE_PLAIN: begin
                  piece_byte  = head.data;
                  piece_final = 1'b1;
               end
               MODE_ESCAPE: begin
                  piece_byte = CHAR_PCT;
               end
               default: begin
                  piece_has   = 1'b0;
                  piece_final = 1'b1;
               end
            endcase
         end
         PH_HEX_HI: begin
            piece_byte = hex_digit(head.data[7:4]);
         end
         PH_HEX_LO: begin
            piece_byte  = hex_digit(head.data[3:0]);
            piece_final = 1'b1;
         end
         default: begin
            piece_byte = 8'h00;
         end
      endcase
      piece_last = piece_final && head.last;
   end

   assign out_valid_in = advance || (out_valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEP;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff <= piece_byte;
         has_byte_ff <= piece_has;
         last_ff     <= piece_last;
      end
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_has_byte = has_byte_ff;
   assign rsp_out_last = last_ff;

   a_mid_cmd_held: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_SEP |-> !q_empty)
      else $error("expansion in progress without a command");
   a_hex_escape: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEX_HI || phase_ff == PH_HEX_LO) |-> head.mode == MODE_ESCAPE)
      else $error("hex digit phase on a non-escape command");
   a_bare_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !has_byte_ff |-> last_ff && out_byte_ff == 8'h00)
      else $error("bare marker not flagged as last");

endmodule

### rtl/form_value_percent_encoder.sv
// ----------------------------------------------------------------------------
// form_value_percent_encoder: form message percent encoder, top level
// Path: an input byte is written to the command queue, then expanded by the
//   back end into the result register.
// Throughput: one result character per cycle while results are popped; an
//   input byte gives one character (plain) or three (escape), plus a separator.
// Reset: synchronous; clears field state, empties the command queue and
//   the result register.
// ----------------------------------------------------------------------------
module form_value_percent_encoder
   import fve_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_out_last
);

   cmd_type front_cmd, head;
   logic    cmd_push, q_full, q_empty, q_pop;

   fve_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .cmd_push    (cmd_push),
      .cmd         (front_cmd),
      .q_full      (q_full)
   );

   fve_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (head),
      .empty    (q_empty)
   );

   fve_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_has_byte (rsp_has_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule
